// ----- sv/bpfm_pkg.sv -----
// package for the buffer pool frame manager
// command, status and state codes shared by the block; no dependencies
`timescale 1ns / 1ps

package bpfm_pkg;

  localparam logic [1:0] CMD_GET     = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_DIRTY   = 2'd2;
  localparam logic [1:0] CMD_FLUSH   = 2'd3;

  localparam logic [2:0] ST_HIT    = 3'd0;
  localparam logic [2:0] ST_LOADED = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_UNDER  = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIND = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_MOD  = 2'd3;

  localparam int STAMP_BITS = 32;
  localparam int COUNT_BITS = 32;

  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [COUNT_BITS-1:0] count_t;

endpackage

// ----- sv/bpfm_table.sv -----
// frame entry memory: one write port, one registered read port
// generic in width and depth; no package dependencies
`timescale 1ns / 1ps

module bpfm_table #(
  parameter int WIDTH = 57,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/bpfm_cam.sv -----
// tag lookup: per-frame tag and valid flops with parallel compare
// finds the hit frame and the lowest empty frame; no package dependencies
`timescale 1ns / 1ps

module bpfm_cam #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fill_en,
  input  logic [$clog2(FRAMES)-1:0] fill_idx,
  input  logic [PAGE_BITS-1:0]      fill_tag,
  input  logic [PAGE_BITS-1:0]      look_tag,
  input  logic [$clog2(FRAMES)-1:0] query_idx,
  output logic                      hit,
  output logic [$clog2(FRAMES)-1:0] hit_idx,
  output logic                      free_any,
  output logic [$clog2(FRAMES)-1:0] free_idx,
  output logic                      query_valid
);

  localparam int IDX_W = $clog2(FRAMES);

  logic [PAGE_BITS-1:0] tag_r [FRAMES];
  logic [FRAMES-1:0]    valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (fill_en) begin
      valid_r[fill_idx] <= 1'b1;
    end
    if (fill_en) begin
      tag_r[fill_idx] <= fill_tag;
    end
  end

  // lowest matching and lowest empty frame win
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (valid_r[i] && tag_r[i] == look_tag) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign query_valid = valid_r[query_idx];

endmodule

// ----- sv/buffer_pool_frame_manager_top.sv -----
// top level of the buffer pool frame manager: command sequencer and read-modify-write
// uses bpfm_pkg, bpfm_cam and bpfm_table
`timescale 1ns / 1ps

// A command is taken when start is high and busy low. Its result appears for
// exactly one cycle with out_valid high; the receiver cannot stall it, so it
// must take every result when it comes. A hit, a miss into an empty frame,
// release, mark dirty and flush first look up the frame (a get compares the
// tag across all frames, the others take the slot) and read the frame's entry
// from the table memory, then modify the entry and write it back. A miss with
// every frame filled scans the table one entry a cycle for the least recently
// used unpinned frame before the modify step, or answers at the end of the
// scan when none exists. A release, mark dirty or flush on a slot of FRAMES
// or more answers from the lookup step without touching the table. busy is
// high from the accept until the result cycle, so the next command can be
// taken at the edge that ends the result cycle. Page data and disk transfers
// stay outside; the block only reports the write-back and load that are due.
module buffer_pool_frame_manager_top
  import bpfm_pkg::*;
#(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16,
  parameter int PIN_BITS  = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_command,
  input  logic [PAGE_BITS-1:0] in_page_number,
  input  logic [3:0]           in_frame_slot,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [3:0]           out_result_frame,
  output logic                 out_writeback_needed,
  output logic [PAGE_BITS-1:0] out_writeback_page,
  output logic                 out_load_needed,
  output logic [PIN_BITS-1:0]  out_pins_now,
  output logic [31:0]          out_fault_total,
  output logic [31:0]          out_write_total
);

  localparam int IDX_W = $clog2(FRAMES);
  localparam int ENT_W = PAGE_BITS + 1 + PIN_BITS + STAMP_BITS;
  localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

  // sequencer state
  logic [1:0]           state_r, state_nxt;
  logic [1:0]           cmd_r;
  logic [PAGE_BITS-1:0] page_r;
  logic [3:0]           slot_r;
  logic [IDX_W-1:0]     op_idx_r, op_idx_nxt;
  logic                 hit_r, hit_nxt;
  logic [IDX_W:0]       scan_r, scan_nxt;
  logic                 best_found_r, best_found_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  stamp_t               best_stamp_r, best_stamp_nxt;
  stamp_t               clock_r, clock_nxt;
  count_t               fault_r, fault_nxt;
  count_t               write_r, write_nxt;

  // result registers
  logic                 ovalid_r, ovalid_nxt;
  logic [2:0]           ostatus_r, ostatus_nxt;
  logic [3:0]           oframe_r, oframe_nxt;
  logic                 owb_r, owb_nxt;
  logic [PAGE_BITS-1:0] owbpage_r, owbpage_nxt;
  logic                 oload_r, oload_nxt;
  logic [PIN_BITS-1:0]  opins_r, opins_nxt;

  // table and lookup wiring
  logic                 cam_hit, cam_free;
  logic [IDX_W-1:0]     cam_hit_idx, cam_free_idx;
  logic                 op_valid;
  logic                 fill_en;
  logic                 tbl_we;
  logic [IDX_W-1:0]     rd_addr;
  logic [ENT_W-1:0]     rd_data, wr_data;

  logic                 slot_ok;
  logic [IDX_W-1:0]     slot_idx;
  logic [31:0]          slot_ext;

  // entry fields of the frame under work; empty frames read as reset
  logic [PAGE_BITS-1:0] e_tag;
  logic                 e_dirty;
  logic [PIN_BITS-1:0]  e_pins;
  stamp_t               e_stamp;
  logic [PAGE_BITS-1:0] n_tag;
  logic                 n_dirty;
  logic [PIN_BITS-1:0]  n_pins;
  stamp_t               n_stamp;

  // fields of the entry arriving during the scan
  logic [PIN_BITS-1:0]  s_pins;
  stamp_t               s_stamp;

  assign slot_ext = 32'(slot_r);
  assign slot_ok  = slot_ext < 32'(FRAMES);
  assign slot_idx = slot_ext[IDX_W-1:0];

  assign s_pins  = rd_data[STAMP_BITS +: PIN_BITS];
  assign s_stamp = rd_data[STAMP_BITS-1:0];

  always_comb begin
    if (op_valid) begin
      e_tag   = rd_data[ENT_W-1 -: PAGE_BITS];
      e_dirty = rd_data[STAMP_BITS + PIN_BITS];
      e_pins  = rd_data[STAMP_BITS +: PIN_BITS];
      e_stamp = rd_data[STAMP_BITS-1:0];
    end else begin
      e_tag   = '0;
      e_dirty = 1'b0;
      e_pins  = '0;
      e_stamp = '0;
    end
  end

  bpfm_cam #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_cam (
    .clk         (clk),
    .rst_n       (rst_n),
    .fill_en     (fill_en),
    .fill_idx    (op_idx_r),
    .fill_tag    (page_r),
    .look_tag    (page_r),
    .query_idx   (op_idx_r),
    .hit         (cam_hit),
    .hit_idx     (cam_hit_idx),
    .free_any    (cam_free),
    .free_idx    (cam_free_idx),
    .query_valid (op_valid)
  );

  bpfm_table #(
    .WIDTH (ENT_W),
    .DEPTH (FRAMES)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (op_idx_r),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign wr_data = {n_tag, n_dirty, n_pins, n_stamp};

  always_comb begin
    state_nxt      = state_r;
    op_idx_nxt     = op_idx_r;
    hit_nxt        = hit_r;
    scan_nxt       = scan_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_stamp_nxt = best_stamp_r;
    clock_nxt      = clock_r;
    fault_nxt      = fault_r;
    write_nxt      = write_r;
    ovalid_nxt     = 1'b0;
    ostatus_nxt    = ST_DONE;
    oframe_nxt     = '0;
    owb_nxt        = 1'b0;
    owbpage_nxt    = '0;
    oload_nxt      = 1'b0;
    opins_nxt      = '0;
    rd_addr        = op_idx_r;
    fill_en        = 1'b0;
    tbl_we         = 1'b0;
    n_tag          = e_tag;
    n_dirty        = e_dirty;
    n_pins         = e_pins;
    n_stamp        = e_stamp;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_FIND;
        end
      end

      S_FIND: begin
        if (cmd_r == CMD_GET) begin
          if (cam_hit) begin
            hit_nxt    = 1'b1;
            op_idx_nxt = cam_hit_idx;
            rd_addr    = cam_hit_idx;
            state_nxt  = S_MOD;
          end else begin
            hit_nxt   = 1'b0;
            fault_nxt = fault_r + 1'b1;
            if (cam_free) begin
              op_idx_nxt = cam_free_idx;
              rd_addr    = cam_free_idx;
              state_nxt  = S_MOD;
            end else begin
              // every frame filled: sweep the table for the oldest unpinned one
              rd_addr        = '0;
              scan_nxt       = (IDX_W + 1)'(1);
              best_found_nxt = 1'b0;
              state_nxt      = S_SCAN;
            end
          end
        end else if (slot_ok) begin
          op_idx_nxt = slot_idx;
          rd_addr    = slot_idx;
          state_nxt  = S_MOD;
        end else begin
          ovalid_nxt  = 1'b1;
          ostatus_nxt = ST_DONE;
          oframe_nxt  = slot_r;
          state_nxt   = S_IDLE;
        end
      end

      S_SCAN: begin
        // rd_data holds the entry of frame scan_r - 1
        if (s_pins == '0 && (!best_found_r || s_stamp < best_stamp_r)) begin
          best_found_nxt = 1'b1;
          best_idx_nxt   = IDX_W'(scan_r - 1'b1);
          best_stamp_nxt = s_stamp;
        end
        scan_nxt = scan_r + 1'b1;
        if (scan_r < (IDX_W + 1)'(FRAMES)) begin
          rd_addr = scan_r[IDX_W-1:0];
        end else begin
          rd_addr = best_idx_nxt;
          if (best_found_nxt) begin
            op_idx_nxt = best_idx_nxt;
            state_nxt  = S_MOD;
          end else begin
            ovalid_nxt  = 1'b1;
            ostatus_nxt = ST_FULL;
            state_nxt   = S_IDLE;
          end
        end
      end

      S_MOD: begin
        tbl_we     = 1'b1;
        ovalid_nxt = 1'b1;
        oframe_nxt = 4'(op_idx_r);
        state_nxt  = S_IDLE;
        unique case (cmd_r)
          CMD_GET: begin
            n_stamp   = clock_r;
            clock_nxt = clock_r + 1'b1;
            if (hit_r) begin
              if (e_pins != PIN_MAX) begin
                n_pins = e_pins + 1'b1;
              end
              ostatus_nxt = ST_HIT;
            end else begin
              if (op_valid && e_dirty) begin
                owb_nxt     = 1'b1;
                owbpage_nxt = e_tag;
                write_nxt   = write_r + 1'b1;
              end
              fill_en     = 1'b1;
              n_tag       = page_r;
              n_dirty     = 1'b0;
              n_pins      = PIN_BITS'(1);
              ostatus_nxt = ST_LOADED;
              oload_nxt   = 1'b1;
            end
          end
          CMD_RELEASE: begin
            if (e_pins == '0) begin
              ostatus_nxt = ST_UNDER;
            end else begin
              n_pins = e_pins - 1'b1;
            end
          end
          CMD_DIRTY: begin
            if (op_valid) begin
              n_dirty = 1'b1;
            end
          end
          CMD_FLUSH: begin
            if (op_valid && e_dirty) begin
              owb_nxt     = 1'b1;
              owbpage_nxt = e_tag;
              n_dirty     = 1'b0;
              write_nxt   = write_r + 1'b1;
            end
          end
          default: begin
          end
        endcase
        opins_nxt = n_pins;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      clock_r      <= stamp_t'(1);
      fault_r      <= '0;
      write_r      <= '0;
      ovalid_r     <= 1'b0;
      hit_r        <= 1'b0;
      best_found_r <= 1'b0;
      scan_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      clock_r      <= clock_nxt;
      fault_r      <= fault_nxt;
      write_r      <= write_nxt;
      ovalid_r     <= ovalid_nxt;
      hit_r        <= hit_nxt;
      best_found_r <= best_found_nxt;
      scan_r       <= scan_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      cmd_r  <= in_command;
      page_r <= in_page_number;
      slot_r <= in_frame_slot;
    end
    op_idx_r     <= op_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_stamp_r <= best_stamp_nxt;
    ostatus_r    <= ostatus_nxt;
    oframe_r     <= oframe_nxt;
    owb_r        <= owb_nxt;
    owbpage_r    <= owbpage_nxt;
    oload_r      <= oload_nxt;
    opins_r      <= opins_nxt;
  end

  assign busy                 = state_r != S_IDLE;
  assign out_valid            = ovalid_r;
  assign out_status           = ostatus_r;
  assign out_result_frame     = oframe_r;
  assign out_writeback_needed = owb_r;
  assign out_writeback_page   = owbpage_r;
  assign out_load_needed      = oload_r;
  assign out_pins_now         = opins_r;
  assign out_fault_total      = fault_r;
  assign out_write_total      = write_r;

endmodule

// ----- dv/buffer_pool_frame_manager_top_tb.sv -----
// self-checking testbench for the buffer pool frame manager top level
// drives get/release/dirty/flush commands, predicts every result in a frame table model
// depends on bpfm_pkg and buffer_pool_frame_manager_top
`timescale 1ns / 1ps

module buffer_pool_frame_manager_top_tb;
  import bpfm_pkg::*;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 16;
  localparam int PIN_BITS  = 8;
  localparam int N_RANDOM  = 390;
  localparam int QUIET_TAIL = 100;   // no random gaps after the last items
  localparam logic [PIN_BITS-1:0] PIN_FULL = '1;

  // one command item, with a flag to hold it until every result is back
  typedef struct {
    logic [1:0]           cmd;
    logic [PAGE_BITS-1:0] page;
    logic [3:0]           slot;
    bit                   drain;
  } cmd_item_t;

  // one result item, field by field as on the ports
  typedef struct {
    logic [2:0]           status;
    logic [3:0]           frame;
    logic                 wb;
    logic [PAGE_BITS-1:0] wb_page;
    logic                 load;
    logic [PIN_BITS-1:0]  pins;
    logic [31:0]          faults;
    logic [31:0]          writes;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0]           in_command = CMD_GET;
  logic [PAGE_BITS-1:0] in_page_number = '0;
  logic [3:0]           in_frame_slot = '0;
  logic                 out_valid;
  logic [2:0]           out_status;
  logic [3:0]           out_result_frame;
  logic                 out_writeback_needed;
  logic [PAGE_BITS-1:0] out_writeback_page;
  logic                 out_load_needed;
  logic [PIN_BITS-1:0]  out_pins_now;
  logic [31:0]          out_fault_total;
  logic [31:0]          out_write_total;

  always #5 clk = ~clk;

  buffer_pool_frame_manager_top #(
    .FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS), .PIN_BITS(PIN_BITS)
  ) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_page_number(in_page_number),
    .in_frame_slot(in_frame_slot), .out_valid(out_valid),
    .out_status(out_status), .out_result_frame(out_result_frame),
    .out_writeback_needed(out_writeback_needed),
    .out_writeback_page(out_writeback_page),
    .out_load_needed(out_load_needed), .out_pins_now(out_pins_now),
    .out_fault_total(out_fault_total), .out_write_total(out_write_total)
  );

  // frame table as the testbench sees it
  logic [PAGE_BITS-1:0] tbl_tag   [FRAMES];
  logic                 tbl_valid [FRAMES];
  logic                 tbl_dirty [FRAMES];
  logic [PIN_BITS-1:0]  tbl_pins  [FRAMES];
  logic [31:0]          tbl_stamp [FRAMES];
  logic [31:0]          use_clock;
  logic [31:0]          fault_cnt;
  logic [31:0]          write_cnt;

  cmd_item_t     pending_cmds[$];
  frame_result_t awaited_results[$];

  int  accepted_n = 0;
  int  posted_n = 0;
  int  total_items = 0;
  int  idle_left = 0;
  bit  failed = 0;
  int  n_hit = 0, n_load = 0, n_full = 0, n_under = 0, n_wb = 0;

  // work out the result of one command and update the table copy
  task automatic predict_frame_op(input cmd_item_t it);
    frame_result_t r;
    int hit_idx;
    int victim;
    int s;
    r = '{status: ST_DONE, frame: '0, wb: 1'b0, wb_page: '0, load: 1'b0,
          pins: '0, faults: '0, writes: '0};
    s = it.slot;
    if (it.cmd == CMD_GET) begin
      hit_idx = -1;
      for (int i = FRAMES - 1; i >= 0; i--)
        if (tbl_valid[i] && tbl_tag[i] == it.page) hit_idx = i;
      if (hit_idx >= 0) begin
        if (tbl_pins[hit_idx] != PIN_FULL) tbl_pins[hit_idx]++;
        tbl_stamp[hit_idx] = use_clock;
        use_clock++;
        r.status = ST_HIT;
        r.frame = hit_idx[3:0];
        r.pins = tbl_pins[hit_idx];
      end else begin
        fault_cnt++;
        victim = -1;
        // lowest empty frame wins, else the oldest unpinned one
        for (int i = FRAMES - 1; i >= 0; i--)
          if (!tbl_valid[i]) victim = i;
        if (victim < 0)
          for (int i = 0; i < FRAMES; i++)
            if (tbl_pins[i] == 0 && (victim < 0 || tbl_stamp[i] < tbl_stamp[victim]))
              victim = i;
        if (victim < 0) begin
          r.status = ST_FULL;
        end else begin
          if (tbl_valid[victim] && tbl_dirty[victim]) begin
            r.wb = 1'b1;
            r.wb_page = tbl_tag[victim];
            write_cnt++;
          end
          tbl_tag[victim] = it.page;
          tbl_valid[victim] = 1'b1;
          tbl_dirty[victim] = 1'b0;
          tbl_pins[victim] = 1;
          tbl_stamp[victim] = use_clock;
          use_clock++;
          r.status = ST_LOADED;
          r.frame = victim[3:0];
          r.load = 1'b1;
          r.pins = 1;
        end
      end
    end else begin
      r.frame = it.slot;
      if (s < FRAMES) begin
        case (it.cmd)
          CMD_RELEASE: begin
            if (tbl_pins[s] == 0) r.status = ST_UNDER;
            else tbl_pins[s]--;
          end
          CMD_DIRTY: begin
            if (tbl_valid[s]) tbl_dirty[s] = 1'b1;
          end
          default: begin
            if (tbl_valid[s] && tbl_dirty[s]) begin
              r.wb = 1'b1;
              r.wb_page = tbl_tag[s];
              tbl_dirty[s] = 1'b0;
              write_cnt++;
            end
          end
        endcase
        r.pins = tbl_pins[s];
      end
    end
    r.faults = fault_cnt;
    r.writes = write_cnt;
    awaited_results.push_back(r);
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      failed = 1;
    end
  endfunction

  // monitor: take accepted commands into the predictor, compare results
  always @(posedge clk) begin
    frame_result_t e;
    if (rst_n) begin
      if (start && !busy) begin
        predict_frame_op('{cmd: in_command, page: in_page_number,
                           slot: in_frame_slot, drain: 1'b0});
        accepted_n++;
      end
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $error("result item with nothing expected");
          failed = 1;
        end else begin
          e = awaited_results.pop_front();
          check_field("status", e.status, out_status);
          check_field("result_frame", e.frame, out_result_frame);
          check_field("writeback_needed", e.wb, out_writeback_needed);
          check_field("writeback_page", e.wb_page, out_writeback_page);
          check_field("load_needed", e.load, out_load_needed);
          check_field("pins_now", e.pins, out_pins_now);
          check_field("fault_total", e.faults, out_fault_total);
          check_field("write_total", e.writes, out_write_total);
          case (e.status)
            ST_HIT:    n_hit++;
            ST_LOADED: n_load++;
            ST_FULL:   n_full++;
            ST_UNDER:  n_under++;
            default: ;
          endcase
          if (e.wb) n_wb++;
        end
      end
    end
  end

  // driver: present the next item once the previous one has gone in
  always @(negedge clk) begin
    cmd_item_t it;
    if (rst_n && accepted_n == posted_n) begin
      if (idle_left > 0) begin
        start <= 1'b0;
        idle_left--;
      end else if (pending_cmds.size() != 0 &&
                   !(pending_cmds[0].drain && awaited_results.size() != 0)) begin
        it = pending_cmds.pop_front();
        in_command <= it.cmd;
        in_page_number <= it.page;
        in_frame_slot <= it.slot;
        start <= 1'b1;
        posted_n++;
        // random gap after this item, none near the end
        if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
          idle_left = $urandom_range(1, 4);
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic queue_cmd(input logic [1:0] c, input logic [PAGE_BITS-1:0] p,
                           input logic [3:0] s, input bit d = 0);
    pending_cmds.push_back('{cmd: c, page: p, slot: s, drain: d});
  endtask

  logic [PAGE_BITS-1:0] page_pool [24];

  initial begin
    int pick;
    logic [PAGE_BITS-1:0] pg;
    for (int i = 0; i < FRAMES; i++) begin
      tbl_tag[i] = '0; tbl_valid[i] = 0; tbl_dirty[i] = 0;
      tbl_pins[i] = '0; tbl_stamp[i] = '0;
    end
    use_clock = 1; fault_cnt = 0; write_cnt = 0;

    // empty frames: mark dirty and flush do nothing, release underflows
    queue_cmd(CMD_DIRTY, '0, 4'd5);
    queue_cmd(CMD_FLUSH, '0, 4'd5);
    queue_cmd(CMD_RELEASE, '0, 4'd15);
    // fill every frame and keep them all pinned, then one more miss
    queue_cmd(CMD_GET, 16'h0000, '0);
    queue_cmd(CMD_GET, 16'hFFFF, '0);
    for (int i = 2; i < FRAMES; i++) queue_cmd(CMD_GET, 16'(i * 16'h1111 + 7), '0);
    queue_cmd(CMD_GET, 16'hA5A5, '0);
    queue_cmd(CMD_GET, 16'h0000, '0);          // hit
    // dirty two frames, release each frame once (frame 0 stays pinned), then evictions
    queue_cmd(CMD_DIRTY, '0, 4'd0);
    queue_cmd(CMD_DIRTY, '0, 4'd1);
    queue_cmd(CMD_FLUSH, '0, 4'd1);             // flush a dirty frame
    queue_cmd(CMD_FLUSH, '0, 4'd1);             // now clean
    for (int i = 0; i < FRAMES; i++) queue_cmd(CMD_RELEASE, '0, 4'(i));
    queue_cmd(CMD_RELEASE, '0, 4'd1);
    queue_cmd(CMD_GET, 16'h5A5A, '0, 1);
    queue_cmd(CMD_GET, 16'h1234, '0);
    // pin count saturation on one frame, then unpin another frame past zero
    for (int i = 0; i < 260; i++) queue_cmd(CMD_GET, 16'h5A5A, '0);
    for (int i = 0; i < 258; i++) queue_cmd(CMD_RELEASE, '0, 4'(0));

    // random part: mostly pages from a small pool so hits and evictions mix
    for (int i = 0; i < 24; i++) page_pool[i] = 16'($urandom);
    page_pool[0] = 16'h0000;
    page_pool[1] = 16'hFFFF;
    for (int n = 0; n < N_RANDOM; n++) begin
      pick = $urandom_range(0, 99);
      pg = ($urandom_range(0, 4) == 0) ? 16'($urandom) : page_pool[$urandom_range(0, 23)];
      if (pick < 38)      queue_cmd(CMD_GET, pg, 4'($urandom), n == N_RANDOM / 2);
      else if (pick < 72) queue_cmd(CMD_RELEASE, 16'($urandom), 4'($urandom));
      else if (pick < 88) queue_cmd(CMD_DIRTY, 16'($urandom), 4'($urandom));
      else                queue_cmd(CMD_FLUSH, 16'($urandom), 4'($urandom));
    end
    total_items = pending_cmds.size();

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    wait (accepted_n == total_items && awaited_results.size() == 0);
    repeat (30) @(posedge clk);
    $display("%0d commands: %0d hits, %0d loads, %0d no-frame misses, %0d unpinned releases",
             total_items, n_hit, n_load, n_full, n_under);
    $display("%0d write-backs, %0d faults in total", n_wb, fault_cnt);
    if (!failed && awaited_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
